// ===== design/lpqsd_pkg.sv =====
// Shared types and constants of the quarter-scan LED panel driver.
`default_nettype none

package lpqsd_pkg;

  localparam int unsigned PANEL_WIDTH_DEF  = 32;
  localparam int unsigned PANEL_HEIGHT_DEF = 16;
  localparam int unsigned RAM_DEPTH_DEF    = 512;
  localparam int unsigned BAND_ROWS        = 16;
  localparam int unsigned BAND_BITS        = 4;
  localparam int unsigned CFG_ADDR_W       = 3;

  localparam logic [6:0] BRIGHT_MAX   = 7'd100;
  localparam logic [6:0] BRIGHT_RESET = 7'd100;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_PRESENT = 2'd1;
  localparam logic [1:0] MODE_SCAN    = 2'd2;

  localparam logic REG_BRIGHTNESS = 1'b0;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic       pixel_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic [1:0] row_address;
    logic [7:0] enable_time;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/lpqsd_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module lpqsd_ram
  import lpqsd_pkg::*;
#(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = RAM_DEPTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/led_panel_quarter_scan_driver.sv =====
// Top level of the monochrome quarter-scan LED panel driver.
// A write item goes straight into the draw store while the driver stays idle. A present
// item copies one pixel per cycle through the single port of the draw store, and the
// input stalls until it is done. A scan item builds each byte bit by bit from the display
// store, 4*ceil(DISP_W/8) bytes in all (16 by default), and the output side may stall
// each byte. After reset a clearing pass zeroes both stores before the first item is
// taken; configuration writes are taken throughout.
`default_nettype none

module led_panel_quarter_scan_driver
  import lpqsd_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  localparam int unsigned BANDS     = (PANEL_HEIGHT + BAND_ROWS - 1) / BAND_ROWS;
  localparam int unsigned DISP_W    = BANDS * PANEL_WIDTH;
  localparam int unsigned DRAW_SIZE = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int unsigned DISP_SIZE = DISP_W * BAND_ROWS;
  localparam int unsigned DWW       = (DISP_W + 7) / 8;
  localparam int unsigned DA_W      = $clog2(DRAW_SIZE);
  localparam int unsigned PA_W      = $clog2(DISP_SIZE);
  localparam int unsigned XC_W      = $clog2(PANEL_WIDTH);
  localparam int unsigned YC_W      = $clog2(PANEL_HEIGHT);
  localparam int unsigned CX_W      = $clog2(DWW * 8);

  typedef enum logic [4:0] {
    ST_CLEAR     = 5'b00001,
    ST_IDLE      = 5'b00010,
    ST_PRESENT   = 5'b00100,
    ST_SCAN_RD   = 5'b01000,
    ST_SCAN_EMIT = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [PA_W-1:0]   clr_q, clr_d;
  logic [DA_W-1:0]   rd_q, rd_d;
  logic [XC_W-1:0]   x_q, x_d;
  logic [YC_W-1:0]   y_q, y_d;
  logic              wr_en_q;
  logic [PA_W-1:0]   wr_addr_q;
  logic [CX_W-1:0]   col_q, col_d;
  logic [1:0]        row_q, row_d;
  logic [1:0]        group_q, group_d;
  logic              last_q, last_d;
  logic              rd_valid_q, rd_valid_d;
  logic              in_rng_q;
  logic [7:0]        acc_q;
  logic [7:0]        acc_next;
  logic [6:0]        bright_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              in_accept;
  logic              out_free;
  logic              emit;
  logic              cfg_write;
  logic              wr_in_range;
  logic [DA_W-1:0]   wr_pix_addr;
  logic [PA_W-1:0]   pres_disp_addr;
  logic [3:0]        scan_dy;
  logic [PA_W-1:0]   scan_addr;
  logic              scan_in_range;
  logic [6:0]        bright_sat;
  logic [7:0]        enable_time;

  logic              draw_we;
  logic [DA_W-1:0]   draw_addr;
  logic              draw_wdata;
  logic              draw_rdata;
  logic              disp_we;
  logic [PA_W-1:0]   disp_addr;
  logic              disp_wdata;
  logic              disp_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = (state_q == ST_SCAN_EMIT) && out_free;

  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BRIGHTNESS);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_BRIGHTNESS) ? {25'd0, bright_q} : 32'd0;

  assign wr_in_range = (in_item_i.pos_x < 8'(PANEL_WIDTH)) &&
                       (in_item_i.pos_y < 8'(PANEL_HEIGHT));
  assign wr_pix_addr = DA_W'(32'(in_item_i.pos_y) * PANEL_WIDTH + 32'(in_item_i.pos_x));

  assign pres_disp_addr = PA_W'(32'(y_q[BAND_BITS-1:0]) * DISP_W +
                                32'(y_q >> BAND_BITS) * PANEL_WIDTH + 32'(x_q));

  assign scan_dy       = {~row_q, group_q};
  assign scan_addr     = PA_W'(32'(scan_dy) * DISP_W + 32'(col_q));
  assign scan_in_range = (32'(col_q) < DISP_W);

  assign bright_sat  = (bright_q > BRIGHT_MAX) ? BRIGHT_MAX : bright_q;
  assign enable_time = 8'((9'(bright_sat) * 9'd5) >> 1);

  assign acc_next = rd_valid_q ? {acc_q[6:0], ~(disp_rdata & in_rng_q)} : acc_q;

  always_comb begin
    draw_we    = 1'b0;
    draw_addr  = rd_q;
    draw_wdata = 1'b0;
    disp_we    = 1'b0;
    disp_addr  = scan_addr;
    disp_wdata = draw_rdata;
    if (state_q == ST_CLEAR) begin
      draw_we   = (32'(clr_q) < DRAW_SIZE);
      draw_addr = DA_W'(clr_q);
      disp_we   = 1'b1;
      disp_addr = clr_q;
      disp_wdata = 1'b0;
    end else if (in_accept && (in_item_i.mode == MODE_WRITE)) begin
      draw_we    = wr_in_range;
      draw_addr  = wr_pix_addr;
      draw_wdata = in_item_i.pixel_on;
    end
    if (wr_en_q) begin
      disp_we   = 1'b1;
      disp_addr = wr_addr_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    rd_d       = rd_q;
    x_d        = x_q;
    y_d        = y_q;
    col_d      = col_q;
    row_d      = row_q;
    group_d    = group_q;
    last_d     = last_q;
    rd_valid_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == PA_W'(DISP_SIZE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (in_item_i.mode == MODE_PRESENT) begin
            state_d = ST_PRESENT;
            rd_d    = '0;
            x_d     = '0;
            y_d     = '0;
          end else if (in_item_i.mode == MODE_SCAN) begin
            state_d = ST_SCAN_RD;
            col_d   = '0;
            row_d   = '0;
          end
        end
      end
      ST_PRESENT: begin
        rd_d = rd_q + 1'b1;
        if (x_q == XC_W'(PANEL_WIDTH - 1)) begin
          x_d = '0;
          y_d = y_q + 1'b1;
        end else begin
          x_d = x_q + 1'b1;
        end
        if (rd_q == DA_W'(DRAW_SIZE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        rd_valid_d = 1'b1;
        if (col_q[2:0] == 3'd7) begin
          state_d = ST_SCAN_EMIT;
          last_d  = (row_q == 2'd3) && (col_q == CX_W'(DWW * 8 - 1));
          if (row_q == 2'd3) begin
            col_d = col_q + 1'b1;
            row_d = 2'd0;
          end else begin
            col_d = col_q & ~CX_W'(7);
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      ST_SCAN_EMIT: begin
        if (out_free) begin
          if (last_q) begin
            state_d = ST_IDLE;
            group_d = group_q + 1'b1;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rd_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      wr_en_q     <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      group_q     <= '0;
      last_q      <= 1'b0;
      rd_valid_q  <= 1'b0;
      bright_q    <= BRIGHT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      rd_q       <= rd_d;
      x_q        <= x_d;
      y_q        <= y_d;
      wr_en_q    <= (state_q == ST_PRESENT);
      col_q      <= col_d;
      row_q      <= row_d;
      group_q    <= group_d;
      last_q     <= last_d;
      rd_valid_q <= rd_valid_d;
      if (cfg_write) begin
        bright_q <= pwdata[6:0];
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= pres_disp_addr;
    in_rng_q  <= scan_in_range;
    acc_q     <= acc_next;
    if (emit) begin
      out_q.shift_byte  <= acc_next;
      out_q.row_address <= last_q ? group_q : 2'd0;
      out_q.enable_time <= last_q ? enable_time : 8'd0;
      out_q.last        <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  lpqsd_ram #(
    .WIDTH (1),
    .DEPTH (DRAW_SIZE)
  ) u_draw_ram (
    .clk_i   (clk_i),
    .we_i    (draw_we),
    .addr_i  (draw_addr),
    .wdata_i (draw_wdata),
    .rdata_o (draw_rdata)
  );

  lpqsd_ram #(
    .WIDTH (1),
    .DEPTH (DISP_SIZE)
  ) u_disp_ram (
    .clk_i   (clk_i),
    .we_i    (disp_we),
    .addr_i  (disp_addr),
    .wdata_i (disp_wdata),
    .rdata_o (disp_rdata)
  );

endmodule

`default_nettype wire

// ===== verif/tb_led_panel_quarter_scan_driver.sv =====
// Self-checking testbench for the quarter-scan LED panel driver with a pixel-store predictor.
`timescale 1ns / 1ps

module tb_led_panel_quarter_scan_driver;
  import lpqsd_pkg::*;

  localparam int unsigned DISP_W =
      ((PANEL_HEIGHT_DEF + BAND_ROWS - 1) / BAND_ROWS) * PANEL_WIDTH_DEF;
  localparam logic [CFG_ADDR_W-1:0] ADDR_BRIGHTNESS = {REG_BRIGHTNESS, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED     = 3'd4;
  localparam logic [1:0]            MODE_NONE       = 2'd3;
  localparam int                    SETTLE_CYCLES   = 700;
  localparam int                    PHASES          = 6;
  localparam int                    PHASE_ITEMS     = 37;

  class panel_image_tracker;
    bit        draw_px [PANEL_HEIGHT_DEF][PANEL_WIDTH_DEF];
    bit        shown_px [BAND_ROWS][DISP_W];
    bit [1:0]  group;
    bit [6:0]  bright;
    out_item_t pending_bytes [$];
    int        errors;

    function new();
      group  = '0;
      bright = BRIGHT_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
      if (addr == ADDR_BRIGHTNESS) begin
        bright = data[6:0];
      end
    endfunction

    function logic [7:0] on_time();
      int b;
      b = (bright > BRIGHT_MAX) ? BRIGHT_MAX : bright;
      return 8'(b * 250 / 100);
    endfunction

    function void take_command(in_item_t it);
      out_item_t  o;
      logic [7:0] v;
      int         y;
      case (it.mode)
        MODE_WRITE: begin
          if (it.pos_x < PANEL_WIDTH_DEF && it.pos_y < PANEL_HEIGHT_DEF) begin
            draw_px[it.pos_y][it.pos_x] = it.pixel_on;
          end
        end
        MODE_PRESENT: begin
          for (int r = 0; r < PANEL_HEIGHT_DEF; r++) begin
            for (int c = 0; c < PANEL_WIDTH_DEF; c++) begin
              shown_px[r % BAND_ROWS][(r / BAND_ROWS) * PANEL_WIDTH_DEF + c] = draw_px[r][c];
            end
          end
        end
        MODE_SCAN: begin
          for (int xo = 0; xo < DISP_W; xo += 8) begin
            for (int i = 0; i < 4; i++) begin
              y = group + 4 * (3 - i);
              for (int b = 0; b < 8; b++) begin
                v[7-b] = (xo + b < DISP_W) ? shown_px[y][xo+b] : 1'b0;
              end
              o = '0;
              o.shift_byte = ~v;
              pending_bytes.push_back(o);
            end
          end
          o = pending_bytes.pop_back();
          o.row_address = group;
          o.enable_time = on_time();
          o.last = 1'b1;
          pending_bytes.push_back(o);
          group = group + 2'd1;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got.shift_byte !== want.shift_byte) begin
        $display("%0t: shift_byte expected %h actual %h", $time, want.shift_byte,
                 got.shift_byte);
        errors++;
      end
      if (got.row_address !== want.row_address) begin
        $display("%0t: row_address expected %0d actual %0d", $time, want.row_address,
                 got.row_address);
        errors++;
      end
      if (got.enable_time !== want.enable_time) begin
        $display("%0t: enable_time expected %0d actual %0d", $time, want.enable_time,
                 got.enable_time);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  bit                    no_idle;

  panel_image_tracker tracker = new();

  led_panel_quarter_scan_driver u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk_i = ~clk_i;

  function automatic in_item_t make_cmd(logic [1:0] mode, logic [7:0] x, logic [7:0] y,
                                        logic on);
    in_item_t it;
    it.mode     = mode;
    it.pos_x    = x;
    it.pos_y    = y;
    it.pixel_on = on;
    return it;
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    it = make_cmd(MODE_NONE, 8'($urandom), 8'($urandom), 1'($urandom));
    if (pick < 55) begin
      it.mode  = MODE_WRITE;
      it.pos_x = 8'($urandom_range(0, PANEL_WIDTH_DEF - 1));
      it.pos_y = 8'($urandom_range(0, PANEL_HEIGHT_DEF - 1));
    end else if (pick < 63) begin
      it.mode = MODE_WRITE;
    end else if (pick < 73) begin
      it.mode = MODE_PRESENT;
    end else if (pick < 95) begin
      it.mode = MODE_SCAN;
    end
    return it;
  endfunction

  task automatic send_cmd(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    tracker.take_command(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (tracker.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.write_reg(addr, data);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int stall_len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      stall_len = no_idle ? 0 : $urandom_range(0, 6);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
      tracker.check_byte(out_item);
    end
  end

  initial begin
    logic [31:0] level;
    int          counted;
    in_item_t    it;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    no_idle  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_cmd(make_cmd(MODE_SCAN, 8'h00, 8'h00, 1'b0));
    send_cmd(make_cmd(MODE_WRITE, 8'd0, 8'd0, 1'b1));
    send_cmd(make_cmd(MODE_WRITE, 8'd31, 8'd0, 1'b1));
    send_cmd(make_cmd(MODE_WRITE, 8'd0, 8'd15, 1'b1));
    send_cmd(make_cmd(MODE_WRITE, 8'd31, 8'd15, 1'b1));
    send_cmd(make_cmd(MODE_WRITE, 8'd7, 8'd4, 1'b1));
    send_cmd(make_cmd(MODE_WRITE, 8'd8, 8'd8, 1'b1));
    send_cmd(make_cmd(MODE_WRITE, 8'd32, 8'd0, 1'b1));
    send_cmd(make_cmd(MODE_WRITE, 8'd0, 8'd16, 1'b1));
    send_cmd(make_cmd(MODE_WRITE, 8'd255, 8'd255, 1'b1));
    send_cmd(make_cmd(MODE_PRESENT, 8'h00, 8'h00, 1'b0));
    repeat (4) send_cmd(make_cmd(MODE_SCAN, 8'hFF, 8'hFF, 1'b1));
    send_cmd(make_cmd(MODE_WRITE, 8'd0, 8'd0, 1'b0));
    send_cmd(make_cmd(MODE_NONE, 8'hFF, 8'hFF, 1'b1));
    send_cmd(make_cmd(MODE_PRESENT, 8'hFF, 8'hFF, 1'b1));
    send_cmd(make_cmd(MODE_SCAN, 8'h00, 8'h00, 1'b0));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: level = 32'hFFFF_FF80;
        1: level = 32'd127;
        2: level = 32'd100;
        3: level = 32'd1;
        default: level = $urandom;
      endcase
      write_cfg(ADDR_BRIGHTNESS, level);
      if (p == 0) begin
        write_cfg(ADDR_UNUSED, 32'd33);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = random_cmd();
        send_cmd(it);
        if (it.mode != MODE_NONE &&
            !(it.mode == MODE_WRITE &&
              (it.pos_x >= PANEL_WIDTH_DEF || it.pos_y >= PANEL_HEIGHT_DEF))) begin
          counted++;
        end
      end
      no_idle = 1'b0;
      drain();
    end

    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
